// File: hdl/bbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared types and constants for the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bbr_pkg;

    localparam int LINE_DEPTH   = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int ADDR_W       = $clog2(LINE_DEPTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int CFG_W        = 9;
    localparam int CFG_IDX_W    = 1;
    localparam int CHAN_W       = 8;
    localparam int LANES        = 3;
    localparam int PIX_W        = CHAN_W * LANES;
    localparam int WINDOW_COUNT = 9;
    localparam int SUM_W        = CHAN_W + $clog2(WINDOW_COUNT);
    // Division by nine as a multiply by 2^16/9 rounded up; exact for sums
    // up to nine times the largest channel value.
    localparam int DIV_SHIFT    = 16;
    localparam int DIV_RECIP    = ((1 << DIV_SHIFT) + WINDOW_COUNT - 1) / WINDOW_COUNT;
    localparam int RECIP_W      = $clog2(DIV_RECIP + 1);
    localparam int PROD_W       = SUM_W + RECIP_W;
    localparam int CMP_W        = ((ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W) + 1;
    localparam int HCMP_W       = ((ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W) + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              frame_end;
    } result_t;

    typedef logic [WINDOW_COUNT-1:0][CHAN_W-1:0] chan_win_t;

endpackage
`default_nettype wire

// File: hdl/bbr_linebuf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbr_linebuf
// The two line stores: the row two above and the row one above the pixel.
// ----------------------------------------------------------------------------
module bbr_linebuf (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [bbr_pkg::ADDR_W-1:0] rd_addr,
    output logic      [bbr_pkg::PIX_W-1:0]  upper_rd,
    output logic      [bbr_pkg::PIX_W-1:0]  middle_rd,
    input  wire logic                       wr_en,
    input  wire logic [bbr_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [bbr_pkg::PIX_W-1:0]  wr_upper,
    input  wire logic [bbr_pkg::PIX_W-1:0]  wr_middle
);
    import bbr_pkg::*;

    logic [PIX_W-1:0] upper_mem  [LINE_DEPTH];
    logic [PIX_W-1:0] middle_mem [LINE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            upper_rd  <= upper_mem[rd_addr];
            middle_rd <= middle_mem[rd_addr];
        end
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
    end

endmodule
`default_nettype wire

// File: hdl/bbr_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbr_lane
// One colour channel: sums the nine window values and divides by nine.
// ----------------------------------------------------------------------------
module bbr_lane (
    input  wire logic                       clk,
    input  wire logic                       load,
    input  wire bbr_pkg::chan_win_t         window,
    output logic      [bbr_pkg::CHAN_W-1:0] mean
);
    import bbr_pkg::*;

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [PROD_W-1:0] prod;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < WINDOW_COUNT; i++)
        begin
            sum_next = sum_next + SUM_W'(window[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg <= sum_next;
        end
    end

    assign prod = PROD_W'(sum_reg) * PROD_W'(DIV_RECIP);
    assign mean = prod[DIV_SHIFT +: CHAN_W];

endmodule
`default_nettype wire

// File: hdl/box_blur_3x3_rgb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 mean filter over RGB pixels in raster order.
// ----------------------------------------------------------------------------
// A result passes the stage 1, lane sum and output registers after the beat
// of its last pixel. Throughput: one pixel per cycle unless the output stalls;
// line store read, per-channel sum and divide into the output register overlap.
// Border pixels yield no result and leave a bubble that later stages absorb.
// Reset sets width and height to 256 and clears the counters and the stage
// valids; the line stores and window columns are not cleared.
module box_blur_3x3_rgb (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [bbr_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [bbr_pkg::CFG_W-1:0]     wr_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire bbr_pkg::pixel_t               in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output bbr_pkg::result_t                   out_data
);
    import bbr_pkg::*;

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [CMP_W-1:0]  eff_w;
    logic [HCMP_W-1:0] eff_h;

    logic [ADDR_W-1:0] col_reg;
    logic [ADDR_W-1:0] col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic              end_row;
    logic              end_frame;
    logic              emit;
    logic              accept;

    logic              s1_valid_reg;
    logic              s1_emit_reg;
    logic              s1_end_reg;
    logic [ADDR_W-1:0] s1_idx_reg;
    pixel_t            s1_pix_reg;
    logic              s2_valid_reg;
    logic              s2_end_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;

    logic              out_free;
    logic              s2_adv;
    logic              s2_open;
    logic              s1_adv;
    logic              s1_open;

    logic [PIX_W-1:0]            upper_rd;
    logic [PIX_W-1:0]            middle_rd;
    logic [2:0][PIX_W-1:0]       cur;
    logic [1:0][2:0][PIX_W-1:0]  win_reg;
    logic [LANES-1:0][CHAN_W-1:0] lane_mean;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(LINE_DEPTH);
            height_reg <= CFG_W'(MAX_HEIGHT);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_FRAME_WIDTH:  width_reg  <= wr_data;
                REG_FRAME_HEIGHT: height_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // Out-of-range geometry saturates into the supported range.
    always_comb
    begin
        if (CMP_W'(width_reg) < CMP_W'(3))
            eff_w = CMP_W'(3);
        else if (CMP_W'(width_reg) > CMP_W'(LINE_DEPTH))
            eff_w = CMP_W'(LINE_DEPTH);
        else
            eff_w = CMP_W'(width_reg);

        if (HCMP_W'(height_reg) < HCMP_W'(3))
            eff_h = HCMP_W'(3);
        else if (HCMP_W'(height_reg) > HCMP_W'(MAX_HEIGHT))
            eff_h = HCMP_W'(MAX_HEIGHT);
        else
            eff_h = HCMP_W'(height_reg);
    end

    // Pipeline flow: each stage moves on when the one after it has room.
    assign out_free = !out_valid_reg || !out_stall;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s2_open  = !s2_valid_reg || out_free;
    assign s1_adv   = s1_valid_reg && s2_open;
    assign s1_open  = !s1_valid_reg || s1_adv;
    assign in_stall = !s1_open;
    assign accept   = in_valid && s1_open;

    // Raster position
    assign end_row   = (CMP_W'(col_reg) + CMP_W'(1)) >= eff_w;
    assign end_frame = end_row && ((HCMP_W'(row_reg) + HCMP_W'(1)) >= eff_h);
    assign emit      = (row_reg >= ROW_W'(2)) && (col_reg >= ADDR_W'(2));

    always_comb
    begin
        col_next = col_reg + ADDR_W'(1);
        row_next = row_reg;
        if (end_row)
        begin
            col_next = '0;
            row_next = end_frame ? '0 : row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1: line store read in flight with the pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_open)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg <= emit;
            s1_end_reg  <= end_frame;
            s1_idx_reg  <= col_reg;
            s1_pix_reg  <= in_data;
        end
    end

    bbr_linebuf u_linebuf (
        .clk       (clk),
        .rd_en     (accept),
        .rd_addr   (col_reg),
        .upper_rd  (upper_rd),
        .middle_rd (middle_rd),
        .wr_en     (s1_adv),
        .wr_addr   (s1_idx_reg),
        .wr_upper  (middle_rd),
        .wr_middle (s1_pix_reg)
    );

    assign cur[0] = upper_rd;
    assign cur[1] = middle_rd;
    assign cur[2] = s1_pix_reg;

    // Window columns shift on every pixel, emitting or not.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= cur;
        end
    end

    // Stage 2: per-channel lanes hold the window sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= s1_emit_reg;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_end_reg <= s1_end_reg;
        end
    end

    for (genvar c = 0; c < LANES; c++)
    begin : g_lane
        chan_win_t lane_win;

        always_comb
        begin
            for (int r = 0; r < 3; r++)
            begin
                lane_win[3*r]     = win_reg[0][r][PIX_W-1-CHAN_W*c -: CHAN_W];
                lane_win[3*r + 1] = win_reg[1][r][PIX_W-1-CHAN_W*c -: CHAN_W];
                lane_win[3*r + 2] = cur[r][PIX_W-1-CHAN_W*c -: CHAN_W];
            end
        end

        bbr_lane u_lane (
            .clk    (clk),
            .load   (s1_adv),
            .window (lane_win),
            .mean   (lane_mean[c])
        );
    end

    // Stage 3: merge the lane results into the output beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_data_reg.red_out   <= lane_mean[0];
            out_data_reg.green_out <= lane_mean[1];
            out_data_reg.blue_out  <= lane_mean[2];
            out_data_reg.frame_end <= s2_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// File: verif/box_blur_3x3_rgb_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_check
// Watches the configuration port and both pixel channels of the box blur.
// Each accepted input beat goes through a local model of the 3x3 mean filter.
// Each accepted output beat is compared field by field with the oldest
// predicted mean.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_check (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [bbr_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [bbr_pkg::CFG_W-1:0]     wr_data,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire bbr_pkg::pixel_t               in_data,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire bbr_pkg::result_t              out_data,
    output int unsigned                        mismatches,
    output int unsigned                        outstanding,
    output logic                               at_frame_start
);
    import bbr_pkg::*;

    localparam int REPORT_LIMIT = 50;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [PIX_W-1:0] upper_row  [LINE_DEPTH];
    logic [PIX_W-1:0] middle_row [LINE_DEPTH];
    logic [PIX_W-1:0] prev_col   [2][3];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      fail_total;
    result_t          expected_means [$];

    function automatic int unsigned clamp_geometry(input logic [CFG_W-1:0] v,
                                                   input int unsigned hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advances the window by one pixel and returns whether a mean comes out.
    function automatic bit blur_pixel(input pixel_t px, output result_t mean);
        int unsigned      w_eff;
        int unsigned      h_eff;
        int unsigned      idx;
        int unsigned      total;
        logic [PIX_W-1:0] column [3];
        logic [CHAN_W-1:0] lane_mean [LANES];
        bit               end_row;
        bit               end_frame;
        bit               emitted;
        w_eff     = clamp_geometry(width_reg, LINE_DEPTH);
        h_eff     = clamp_geometry(height_reg, MAX_HEIGHT);
        idx       = (col_pos < LINE_DEPTH) ? col_pos : LINE_DEPTH - 1;
        column[0] = upper_row[idx];
        column[1] = middle_row[idx];
        column[2] = px;
        end_row   = (col_pos + 1 >= w_eff);
        end_frame = end_row && (row_pos + 1 >= h_eff);
        emitted   = (row_pos >= 2) && (col_pos >= 2);

        // Lane 0 is red in the top byte, lane 2 is blue in the bottom byte.
        for (int c = 0; c < LANES; c++)
        begin
            total = 0;
            for (int r = 0; r < 3; r++)
                total += prev_col[0][r][PIX_W-1-CHAN_W*c -: CHAN_W]
                       + prev_col[1][r][PIX_W-1-CHAN_W*c -: CHAN_W]
                       + column[r][PIX_W-1-CHAN_W*c -: CHAN_W];
            lane_mean[c] = CHAN_W'(total / WINDOW_COUNT);
        end
        mean.red_out   = lane_mean[0];
        mean.green_out = lane_mean[1];
        mean.blue_out  = lane_mean[2];
        mean.frame_end = end_frame;

        upper_row[idx]  = column[1];
        middle_row[idx] = column[2];
        for (int r = 0; r < 3; r++)
        begin
            prev_col[0][r] = prev_col[1][r];
            prev_col[1][r] = column[r];
        end

        if (end_row)
        begin
            col_pos = 0;
            row_pos = end_frame ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
        return emitted;
    endfunction

    task automatic compare_field(input string name, input logic [CHAN_W-1:0] want,
                                 input logic [CHAN_W-1:0] got);
        if (got !== want)
        begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t predicted;
        result_t want;
        if (!rst_n)
        begin
            width_reg  = CFG_W'(LINE_DEPTH);
            height_reg = CFG_W'(MAX_HEIGHT);
            col_pos    = 0;
            row_pos    = 0;
            fail_total = 0;
            expected_means.delete();
            mismatches     <= 0;
            outstanding    <= 0;
            at_frame_start <= 1'b1;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == REG_FRAME_WIDTH)
                    width_reg = wr_data;
                else
                    height_reg = wr_data;
            end

            // Output is checked before this edge's input is predicted, so a
            // result can never be matched against its own pixel's beat.
            if (out_valid && !out_stall)
            begin
                if (expected_means.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("%0t: result expected none, got %h", $time, out_data);
                end
                else
                begin
                    want = expected_means.pop_front();
                    compare_field("red_out", want.red_out, out_data.red_out);
                    compare_field("green_out", want.green_out, out_data.green_out);
                    compare_field("blue_out", want.blue_out, out_data.blue_out);
                    compare_field("frame_end", CHAN_W'(want.frame_end),
                                  CHAN_W'(out_data.frame_end));
                end
            end

            if (in_valid && !in_stall)
            begin
                if (blur_pixel(in_data, predicted))
                    expected_means.push_back(predicted);
            end

            mismatches     <= fail_total;
            outstanding    <= expected_means.size();
            at_frame_start <= (col_pos == 0) && (row_pos == 0);
        end
    end

endmodule

// File: verif/tb_box_blur_3x3_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_rgb
// Drives frames of random pixels through the 3x3 box blur under a range of
// frame geometries, with random gaps on the input side and random stalls on
// the output side. Prediction and comparison sit in the companion monitor;
// this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_rgb;
    import bbr_pkg::*;

    localparam int PIXEL_BUDGET  = 1950;
    localparam int PHASE_CAP     = 200;
    localparam int SETTLE_CYCLES = 8;
    // The hold starts part way through the interior row of the widest frame,
    // while many pixels of that row are still to be offered.
    localparam int HOLD_AFTER    = 10;
    localparam int HOLD_CYCLES   = 300;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0]     wr_data;
    logic                 in_valid;
    logic                 in_stall;
    pixel_t               in_data;
    logic                 out_valid;
    logic                 out_stall;
    result_t              out_data;

    int unsigned mismatches;
    int unsigned outstanding;
    logic        at_frame_start;

    int unsigned pixels_sent;
    int unsigned w_eff;
    int unsigned h_eff;
    bit          send_burst;
    bit          take_burst;

    always #2 clk = ~clk;

    box_blur_3x3_rgb u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    box_blur_3x3_rgb_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .at_frame_start (at_frame_start)
    );

    function automatic int unsigned effective(input logic [CFG_W-1:0] v,
                                              input int unsigned hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Mostly uniform, with whole lanes forced to black or full scale now and then.
    function automatic pixel_t random_pixel();
        logic [PIX_W-1:0] bits;
        bits = PIX_W'($urandom());
        for (int c = 0; c < LANES; c++)
            case ($urandom_range(0, 7))
                0: bits[c*CHAN_W +: CHAN_W] = '0;
                1: bits[c*CHAN_W +: CHAN_W] = '1;
                default: ;
            endcase
        return pixel_t'(bits);
    endfunction

    // Waits for every predicted mean to arrive, then lets border pixels that
    // are still in the pipeline drain out.
    task automatic wait_idle();
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_geometry(input bit set_w, input logic [CFG_W-1:0] w,
                                input bit set_h, input logic [CFG_W-1:0] h);
        if (set_w)
        begin
            wr_en    <= 1'b1;
            wr_index <= REG_FRAME_WIDTH;
            wr_data  <= w;
            w_eff     = effective(w, LINE_DEPTH);
            @(posedge clk);
        end
        if (set_h)
        begin
            wr_en    <= 1'b1;
            wr_index <= REG_FRAME_HEIGHT;
            wr_data  <= h;
            h_eff     = effective(h, MAX_HEIGHT);
            @(posedge clk);
        end
        wr_en <= 1'b0;
    endtask

    task automatic send_pixel(input pixel_t px);
        int unsigned gap;
        if ($urandom_range(0, 31) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do
            @(posedge clk);
        while (in_stall);
        pixels_sent++;
    endtask

    task automatic run_pixels(input int unsigned n);
        repeat (n) send_pixel(random_pixel());
        in_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned      n;
        int unsigned      area;
        int unsigned      pick;
        logic [CFG_W-1:0] w_new;
        logic [CFG_W-1:0] h_new;
        pixel_t           px;

        rst_n    <= 1'b0;
        wr_en    <= 1'b0;
        wr_index <= REG_FRAME_WIDTH;
        wr_data  <= '0;
        in_valid <= 1'b0;
        in_data  <= '0;
        pixels_sent = 0;
        send_burst  = 1'b0;
        w_eff       = LINE_DEPTH;
        h_eff       = MAX_HEIGHT;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frame, every channel at full scale.
        set_geometry(1'b1, CFG_W'(3), 1'b1, CFG_W'(3));
        repeat (9) send_pixel('1);
        in_valid <= 1'b0;
        wait_idle();

        // Geometry below range saturates to 3x3; blue sums to 204, so the
        // mean is truncated rather than rounded.
        set_geometry(1'b1, CFG_W'(2), 1'b1, CFG_W'(0));
        for (int i = 0; i < 9; i++)
        begin
            px.red_in   = 8'hFF;
            px.green_in = 8'h00;
            px.blue_in  = CHAN_W'(i * i);
            send_pixel(px);
        end
        in_valid <= 1'b0;
        wait_idle();

        // Widest line, then the width shrinks mid-row: the next beat ends
        // both the row and the frame.
        set_geometry(1'b1, CFG_W'(511), 1'b1, CFG_W'(3));
        run_pixels(2 * LINE_DEPTH + 40);
        wait_idle();
        set_geometry(1'b1, CFG_W'(5), 1'b0, '0);
        run_pixels(1);
        wait_idle();

        // Tallest frame cut short by a smaller height part way down.
        set_geometry(1'b1, CFG_W'(3), 1'b1, CFG_W'(256));
        run_pixels(3 * 12);
        wait_idle();
        set_geometry(1'b0, '0, 1'b1, CFG_W'(5));
        run_pixels(3);

        while (pixels_sent < PIXEL_BUDGET)
        begin
            wait_idle();
            if (at_frame_start)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                begin
                    w_new = CFG_W'($urandom_range(256, 511));
                    h_new = CFG_W'($urandom_range(0, 3));
                end
                else if (pick == 1)
                begin
                    w_new = CFG_W'($urandom_range(0, 3));
                    h_new = CFG_W'($urandom_range(200, 511));
                end
                else if (pick == 2)
                begin
                    w_new = CFG_W'($urandom_range(0, 2));
                    h_new = CFG_W'($urandom_range(0, 2));
                end
                else
                begin
                    w_new = CFG_W'($urandom_range(3, 12));
                    h_new = CFG_W'($urandom_range(3, 8));
                end
                if ($urandom_range(0, 3) != 0)
                    set_geometry(1'b1, w_new, 1'b1, h_new);
                area = w_eff * h_eff;
                n    = ($urandom_range(0, 3) != 0) ? area : $urandom_range(1, area);
            end
            else
            begin
                // Mid-frame the line may only get narrower, or the lines above
                // would be read at columns never written this frame.
                if ($urandom_range(0, 1) == 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                        set_geometry(1'b1, CFG_W'($urandom_range(3, w_eff)), 1'b0, '0);
                    else
                        set_geometry(1'b0, '0, 1'b1,
                                     CFG_W'($urandom_range(0, (w_eff > 16) ? 3 : 12)));
                end
                area = w_eff * h_eff;
                n    = $urandom_range(1, area);
            end
            if (n > PHASE_CAP)
                n = PHASE_CAP;
            run_pixels(n);
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        int unsigned gap;
        int unsigned taken;
        bit          hold_done;
        out_stall <= 1'b1;
        taken      = 0;
        hold_done  = 1'b0;
        take_burst = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                take_burst = !take_burst;
            gap = take_burst ? 0 : $urandom_range(0, 6);
            // One long hold so the pipeline backs up and stalls the input.
            if (!hold_done && taken == HOLD_AFTER)
            begin
                gap       = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/bbr_pkg.sv
hdl/bbr_linebuf.sv
hdl/bbr_lane.sv
hdl/box_blur_3x3_rgb.sv
verif/box_blur_3x3_rgb_check.sv
verif/tb_box_blur_3x3_rgb.sv
